>>> rtl/core/mcr_pkg.sv
// Shared types, constants and codes for the motion capture recorder.
package mcr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int AXES_W      = 3 * SAMPLE_BITS;
    localparam int TIME_W      = 32;
    localparam int FT_W        = TIME_W + 1;
    localparam int RUN_W       = 8;

    localparam int RING_DEPTH  = 512;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int RING_FW     = $clog2(RING_DEPTH + 1);
    localparam int RING_SW     = RING_FW + 1;

    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);
    localparam int Q_OW        = Q_CW + 1;
    localparam logic [Q_OW-1:0] Q_LIMIT = Q_OW'(Q_DEPTH);

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_START_LEN = 2'd1;
    localparam logic [1:0] REG_STOP_LEN  = 2'd2;

    localparam logic [15:0]      RST_THRESHOLD = 16'd819;
    localparam logic [RUN_W-1:0] RST_START_LEN = 8'd10;
    localparam logic [RUN_W-1:0] RST_STOP_LEN  = 8'd20;
    localparam logic [RUN_W-1:0] RUN_MAX       = 8'd255;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic signed [SAMPLE_BITS-1:0] gyro_x;
        logic signed [SAMPLE_BITS-1:0] gyro_y;
        logic signed [SAMPLE_BITS-1:0] gyro_z;
        logic [TIME_W-1:0]             time_ms;
    } t_in_item;

    typedef struct packed {
        logic                          is_moving;
        logic                          motion_started;
        logic                          motion_finished;
        logic                          entry_valid;
        logic                          read_moving;
        logic [TIME_W-1:0]             read_time;
        logic signed [SAMPLE_BITS-1:0] read_accel_x;
        logic signed [SAMPLE_BITS-1:0] read_accel_y;
        logic signed [SAMPLE_BITS-1:0] read_accel_z;
        logic signed [SAMPLE_BITS-1:0] read_gyro_x;
        logic signed [SAMPLE_BITS-1:0] read_gyro_y;
        logic signed [SAMPLE_BITS-1:0] read_gyro_z;
    } t_out_item;

    typedef struct packed {
        logic [15:0]      threshold;
        logic [RUN_W-1:0] start_len;
        logic [RUN_W-1:0] stop_len;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [RING_AW-1:0] waddr;
        logic [FT_W-1:0]    ft;
        logic [AXES_W-1:0]  accel;
        logic [AXES_W-1:0]  gyro;
        logic               re;
        logic [RING_AW-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic valid;
        logic is_moving;
        logic started;
        logic finished;
        logic entry_valid;
    } t_front_req;

endpackage

>>> rtl/core/motion_capture_recorder_top.sv
// Top level of the motion capture recorder: register port, front end, ring RAMs, back end.
// An accepted request is registered (front-end request register, ring RAM read data), then
//   written into the result queue, whose oldest entry is presented at the output.
// Throughput: one request per cycle unless stalled, set by the single ring write/read port.
// A four-entry result queue absorbs output stalls before the input stalls.
// Reset (synchronous, active low) clears counters, flags, ring pointers and the queue and
//   loads register defaults; ring contents are not cleared, the fill count guards reads.
module motion_capture_recorder_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mcr_pkg::t_in_item     i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mcr_pkg::t_out_item    o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    mcr_pkg::t_cfg                r_cfg;
    mcr_pkg::t_ram_req            w_ram;
    mcr_pkg::t_front_req          w_req;
    logic [mcr_pkg::Q_CW-1:0]     w_q_count;
    logic [mcr_pkg::FT_W-1:0]     w_ft_rdata;
    logic [mcr_pkg::AXES_W-1:0]   w_accel_rdata, w_gyro_rdata;
    logic                         w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= mcr_pkg::RST_THRESHOLD;
            r_cfg.start_len <= mcr_pkg::RST_START_LEN;
            r_cfg.stop_len  <= mcr_pkg::RST_STOP_LEN;
        end else if (w_cfg_we) begin
            case (paddr[3:2])
                mcr_pkg::REG_THRESHOLD: r_cfg.threshold <= pwdata[15:0];
                mcr_pkg::REG_START_LEN: r_cfg.start_len <= pwdata[mcr_pkg::RUN_W-1:0];
                mcr_pkg::REG_STOP_LEN:  r_cfg.stop_len  <= pwdata[mcr_pkg::RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mcr_pkg::REG_THRESHOLD: prdata = 32'(r_cfg.threshold);
            mcr_pkg::REG_START_LEN: prdata = 32'(r_cfg.start_len);
            mcr_pkg::REG_STOP_LEN:  prdata = 32'(r_cfg.stop_len);
            default:                prdata = '0;
        endcase
    end

    mcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_count  (w_q_count),
        .o_ram      (w_ram),
        .o_req      (w_req)
    );

    mcr_ram #(.WIDTH(mcr_pkg::FT_W), .DEPTH(mcr_pkg::RING_DEPTH)) u_ft_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.ft),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_ft_rdata)
    );

    mcr_ram #(.WIDTH(mcr_pkg::AXES_W), .DEPTH(mcr_pkg::RING_DEPTH)) u_accel_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.accel),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_accel_rdata)
    );

    mcr_ram #(.WIDTH(mcr_pkg::AXES_W), .DEPTH(mcr_pkg::RING_DEPTH)) u_gyro_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.gyro),
        .i_re    (w_ram.re),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_gyro_rdata)
    );

    mcr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (w_req),
        .i_ft_rdata    (w_ft_rdata),
        .i_accel_rdata (w_accel_rdata),
        .i_gyro_rdata  (w_gyro_rdata),
        .o_q_count     (w_q_count),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_data    (o_out_data)
    );

endmodule

>>> rtl/core/mcr_ram.sv
// Generic simple dual-port RAM with registered read.
module mcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/mcr_front.sv
// Front end: accepts requests, classifies motion, tracks runs and ring pointers.
module mcr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mcr_pkg::t_in_item           i_in_data,
    input  mcr_pkg::t_cfg               i_cfg,
    input  logic [mcr_pkg::Q_CW-1:0]    i_q_count,
    output mcr_pkg::t_ram_req           o_ram,
    output mcr_pkg::t_front_req         o_req
);

    logic signed [mcr_pkg::SAMPLE_BITS-1:0] r_prev_x, r_prev_y, r_prev_z;
    logic signed [mcr_pkg::SAMPLE_BITS-1:0] n_prev_x, n_prev_y, n_prev_z;
    logic [mcr_pkg::RUN_W-1:0]   r_mcnt, n_mcnt, r_scnt, n_scnt;
    logic                        r_started, n_started, r_finished, n_finished;
    logic [mcr_pkg::RING_AW-1:0] r_head, n_head;
    logic [mcr_pkg::RING_FW-1:0] r_fill, n_fill;
    mcr_pkg::t_front_req         r_req, n_req;

    logic [mcr_pkg::Q_OW-1:0]    w_occ;
    logic                        w_accept;
    logic                        w_moving;
    logic                        w_full;
    logic [mcr_pkg::RING_SW-1:0] w_sum, w_wrap;
    logic [mcr_pkg::RING_AW-1:0] w_head_inc;

    function automatic logic axis_moved(
        input logic signed [mcr_pkg::SAMPLE_BITS-1:0] now,
        input logic signed [mcr_pkg::SAMPLE_BITS-1:0] prev,
        input logic [15:0]                             thr
    );
        logic signed [mcr_pkg::SAMPLE_BITS:0] d;
        logic [mcr_pkg::SAMPLE_BITS:0]        mag;
        d   = {now[mcr_pkg::SAMPLE_BITS-1], now} - {prev[mcr_pkg::SAMPLE_BITS-1], prev};
        mag = d[mcr_pkg::SAMPLE_BITS] ? (~d + 1'b1) : d;
        return mag > (mcr_pkg::SAMPLE_BITS+1)'(thr);
    endfunction

    assign w_occ      = mcr_pkg::Q_OW'(i_q_count) + mcr_pkg::Q_OW'(r_req.valid);
    assign o_in_stall = w_occ >= mcr_pkg::Q_LIMIT;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_moving = axis_moved(i_in_data.accel_x, r_prev_x, i_cfg.threshold)
                    | axis_moved(i_in_data.accel_y, r_prev_y, i_cfg.threshold)
                    | axis_moved(i_in_data.accel_z, r_prev_z, i_cfg.threshold);

    assign w_full     = r_fill == mcr_pkg::RING_FW'(mcr_pkg::RING_DEPTH);
    assign w_sum      = mcr_pkg::RING_SW'(r_head) + mcr_pkg::RING_SW'(r_fill);
    assign w_wrap     = (w_sum >= mcr_pkg::RING_SW'(mcr_pkg::RING_DEPTH))
                      ? w_sum - mcr_pkg::RING_SW'(mcr_pkg::RING_DEPTH) : w_sum;
    assign w_head_inc = (r_head == mcr_pkg::RING_AW'(mcr_pkg::RING_DEPTH - 1))
                      ? '0 : r_head + 1'b1;

    always_comb begin
        n_prev_x   = r_prev_x;
        n_prev_y   = r_prev_y;
        n_prev_z   = r_prev_z;
        n_mcnt     = r_mcnt;
        n_scnt     = r_scnt;
        n_started  = r_started;
        n_finished = r_finished;
        n_head     = r_head;
        n_fill     = r_fill;
        n_req      = '0;
        o_ram.we    = 1'b0;
        o_ram.waddr = w_full ? r_head : w_wrap[mcr_pkg::RING_AW-1:0];
        o_ram.ft    = {w_moving, i_in_data.time_ms};
        o_ram.accel = {i_in_data.accel_x, i_in_data.accel_y, i_in_data.accel_z};
        o_ram.gyro  = {i_in_data.gyro_x, i_in_data.gyro_y, i_in_data.gyro_z};
        o_ram.re    = 1'b0;
        o_ram.raddr = r_head;
        if (w_accept) begin
            n_req.valid = 1'b1;
            case (i_in_data.opcode)
                mcr_pkg::OP_SAMPLE: begin
                    if (!r_finished) begin
                        n_req.is_moving = w_moving;
                        o_ram.we = 1'b1;
                        if (w_full) begin
                            n_head = w_head_inc;
                        end else begin
                            n_fill = r_fill + 1'b1;
                        end
                        if (w_moving) begin
                            n_mcnt = (r_mcnt < mcr_pkg::RUN_MAX) ? r_mcnt + 1'b1 : r_mcnt;
                            n_scnt = '0;
                        end else begin
                            n_mcnt = '0;
                            if (r_started && r_scnt < mcr_pkg::RUN_MAX) begin
                                n_scnt = r_scnt + 1'b1;
                            end
                        end
                        if (n_mcnt >= i_cfg.start_len) begin
                            n_started = 1'b1;
                        end
                        if (n_scnt >= i_cfg.stop_len) begin
                            n_finished = 1'b1;
                        end
                        n_prev_x = i_in_data.accel_x;
                        n_prev_y = i_in_data.accel_y;
                        n_prev_z = i_in_data.accel_z;
                    end
                end
                mcr_pkg::OP_READ: begin
                    if (r_fill != '0) begin
                        o_ram.re = 1'b1;
                        n_req.entry_valid = 1'b1;
                        n_head = w_head_inc;
                        n_fill = r_fill - 1'b1;
                    end
                end
                mcr_pkg::OP_CLEAR: begin
                    n_head     = '0;
                    n_fill     = '0;
                    n_mcnt     = '0;
                    n_scnt     = '0;
                    n_started  = 1'b0;
                    n_finished = 1'b0;
                end
                default: begin
                end
            endcase
            n_req.started  = n_started;
            n_req.finished = n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_prev_z   <= '0;
            r_mcnt     <= '0;
            r_scnt     <= '0;
            r_started  <= 1'b0;
            r_finished <= 1'b0;
            r_head     <= '0;
            r_fill     <= '0;
            r_req      <= '0;
        end else begin
            r_prev_x   <= n_prev_x;
            r_prev_y   <= n_prev_y;
            r_prev_z   <= n_prev_z;
            r_mcnt     <= n_mcnt;
            r_scnt     <= n_scnt;
            r_started  <= n_started;
            r_finished <= n_finished;
            r_head     <= n_head;
            r_fill     <= n_fill;
            r_req      <= n_req;
        end
    end

    assign o_req = r_req;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= mcr_pkg::RING_FW'(mcr_pkg::RING_DEPTH))
        else $error("ring fill beyond depth");
    a_still_run_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scnt != '0) |-> r_started)
        else $error("still run counted without started");
`endif

endmodule

>>> rtl/core/mcr_back.sv
// Back end: formats results with ring read data and queues them for the output.
module mcr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcr_pkg::t_front_req           i_req,
    input  logic [mcr_pkg::FT_W-1:0]      i_ft_rdata,
    input  logic [mcr_pkg::AXES_W-1:0]    i_accel_rdata,
    input  logic [mcr_pkg::AXES_W-1:0]    i_gyro_rdata,
    output logic [mcr_pkg::Q_CW-1:0]      o_q_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mcr_pkg::t_out_item            o_out_data
);

    mcr_pkg::t_out_item         r_q [mcr_pkg::Q_DEPTH];
    logic [mcr_pkg::Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [mcr_pkg::Q_CW-1:0]   r_count;
    mcr_pkg::t_out_item         w_item;
    logic                       w_push, w_pop;

    always_comb begin
        w_item = '0;
        w_item.is_moving       = i_req.is_moving;
        w_item.motion_started  = i_req.started;
        w_item.motion_finished = i_req.finished;
        if (i_req.entry_valid) begin
            w_item.entry_valid  = 1'b1;
            w_item.read_moving  = i_ft_rdata[mcr_pkg::TIME_W];
            w_item.read_time    = i_ft_rdata[mcr_pkg::TIME_W-1:0];
            {w_item.read_accel_x, w_item.read_accel_y, w_item.read_accel_z} = i_accel_rdata;
            {w_item.read_gyro_x, w_item.read_gyro_y, w_item.read_gyro_z}    = i_gyro_rdata;
        end
    end

    assign w_push      = i_req.valid;
    assign o_out_valid = r_count != '0;
    assign w_pop       = o_out_valid && !i_out_stall;
    assign o_out_data  = r_q[r_rd_ptr];
    assign o_q_count   = r_count;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == mcr_pkg::Q_AW'(mcr_pkg::Q_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == mcr_pkg::Q_AW'(mcr_pkg::Q_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mcr_pkg::Q_CW'(mcr_pkg::Q_DEPTH))
        else $error("result queue count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_count != mcr_pkg::Q_CW'(mcr_pkg::Q_DEPTH)))
        else $error("push into full result queue");
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_count == '0) |=> o_out_valid)
        else $error("pushed result not presented");
`endif

endmodule

>>> test/mcr_checker.sv
`timescale 1ns / 1ps
// Checker for the motion capture recorder: watches both channels and the register port.
module mcr_checker
    import mcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_item          i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_item         i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [3:0]        i_paddr,
    input  logic [31:0]       i_pwdata,
    input  logic [31:0]       i_prdata,
    input  logic              i_pready,
    output int                o_failures,
    output int                o_pending,
    output int                o_taken,
    output logic              o_finished
);

    typedef struct packed {
        logic              moving;
        logic [TIME_W-1:0] stamp;
        logic [AXES_W-1:0] accel;
        logic [AXES_W-1:0] gyro;
    } t_ring_slot;

    logic [15:0]                   motion_thr = RST_THRESHOLD;
    logic [RUN_W-1:0]              start_len  = RST_START_LEN;
    logic [RUN_W-1:0]              stop_len   = RST_STOP_LEN;

    logic signed [SAMPLE_BITS-1:0] prev_accel [3];
    logic [RUN_W-1:0]              move_run;
    logic [RUN_W-1:0]              still_run;
    logic                          started_flag;
    logic                          finished_flag;
    t_ring_slot                    ring_mem [RING_DEPTH];
    logic [RING_AW-1:0]            ring_head;
    logic [RING_FW-1:0]            ring_fill;

    t_out_item                     expected_results [$];
    int                            fail_cnt  = 0;
    int                            taken_cnt = 0;

    function automatic logic axis_exceeds(input logic signed [SAMPLE_BITS-1:0] now,
                                          input logic signed [SAMPLE_BITS-1:0] prior);
        int diff;
        diff = int'(now) - int'(prior);
        if (diff < 0) diff = -diff;
        return diff > int'(motion_thr);
    endfunction

    function automatic t_out_item process_request(input t_in_item req);
        t_out_item          res;
        logic               moving;
        logic [RING_AW-1:0] slot;
        t_ring_slot         e;
        res    = '0;
        moving = 1'b0;
        case (req.opcode)
            OP_SAMPLE: begin
                if (!finished_flag) begin
                    moving = axis_exceeds(req.accel_x, prev_accel[0]) |
                             axis_exceeds(req.accel_y, prev_accel[1]) |
                             axis_exceeds(req.accel_z, prev_accel[2]);
                    if (ring_fill >= RING_FW'(RING_DEPTH)) begin
                        slot = ring_head;
                        ring_head++;
                    end else begin
                        slot = ring_head + ring_fill[RING_AW-1:0];
                        ring_fill++;
                    end
                    ring_mem[slot] = '{moving, req.time_ms,
                                       {req.accel_x, req.accel_y, req.accel_z},
                                       {req.gyro_x, req.gyro_y, req.gyro_z}};
                    if (moving) begin
                        if (move_run != RUN_MAX) move_run++;
                        still_run = '0;
                    end else begin
                        move_run = '0;
                        if (started_flag && still_run != RUN_MAX) still_run++;
                    end
                    if (move_run >= start_len) started_flag = 1'b1;
                    if (still_run >= stop_len) finished_flag = 1'b1;
                    prev_accel[0] = req.accel_x;
                    prev_accel[1] = req.accel_y;
                    prev_accel[2] = req.accel_z;
                end
            end
            OP_READ: begin
                if (ring_fill != '0) begin
                    e               = ring_mem[ring_head];
                    res.entry_valid = 1'b1;
                    res.read_moving = e.moving;
                    res.read_time   = e.stamp;
                    {res.read_accel_x, res.read_accel_y, res.read_accel_z} = e.accel;
                    {res.read_gyro_x, res.read_gyro_y, res.read_gyro_z}    = e.gyro;
                    ring_head++;
                    ring_fill--;
                end
            end
            OP_CLEAR: begin
                ring_head     = '0;
                ring_fill     = '0;
                move_run      = '0;
                still_run     = '0;
                started_flag  = 1'b0;
                finished_flag = 1'b0;
            end
            default: ;
        endcase
        res.is_moving       = moving;
        res.motion_started  = started_flag;
        res.motion_finished = finished_flag;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_cnt++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic compare_result(input t_out_item want, input t_out_item got);
        check_field("is_moving", 32'(want.is_moving), 32'(got.is_moving));
        check_field("motion_started", 32'(want.motion_started), 32'(got.motion_started));
        check_field("motion_finished", 32'(want.motion_finished),
                    32'(got.motion_finished));
        check_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
        check_field("read_moving", 32'(want.read_moving), 32'(got.read_moving));
        check_field("read_time", want.read_time, got.read_time);
        check_field("read_accel_x", 32'(want.read_accel_x), 32'(got.read_accel_x));
        check_field("read_accel_y", 32'(want.read_accel_y), 32'(got.read_accel_y));
        check_field("read_accel_z", 32'(want.read_accel_z), 32'(got.read_accel_z));
        check_field("read_gyro_x", 32'(want.read_gyro_x), 32'(got.read_gyro_x));
        check_field("read_gyro_y", 32'(want.read_gyro_y), 32'(got.read_gyro_y));
        check_field("read_gyro_z", 32'(want.read_gyro_z), 32'(got.read_gyro_z));
    endtask

    always @(posedge i_clk) begin
        t_out_item   want;
        logic [31:0] reg_value;
        if (!i_rst_n) begin
            motion_thr    = RST_THRESHOLD;
            start_len     = RST_START_LEN;
            stop_len      = RST_STOP_LEN;
            prev_accel    = '{default: '0};
            move_run      = '0;
            still_run     = '0;
            started_flag  = 1'b0;
            finished_flag = 1'b0;
            ring_head     = '0;
            ring_fill     = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: result expected none actual %0h", $time, i_out_data);
                end else begin
                    want = expected_results.pop_front();
                    compare_result(want, i_out_data);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                taken_cnt++;
                expected_results.push_back(process_request(i_in_data));
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (i_paddr[3:2])
                        REG_THRESHOLD: motion_thr = i_pwdata[15:0];
                        REG_START_LEN: start_len  = i_pwdata[RUN_W-1:0];
                        REG_STOP_LEN:  stop_len   = i_pwdata[RUN_W-1:0];
                        default: ;
                    endcase
                end else if (i_paddr[3:2] != 2'd3) begin
                    case (i_paddr[3:2])
                        REG_THRESHOLD: reg_value = {16'd0, motion_thr};
                        REG_START_LEN: reg_value = {24'd0, start_len};
                        default:       reg_value = {24'd0, stop_len};
                    endcase
                    check_field("prdata", reg_value, i_prdata);
                end
            end
        end
        o_failures <= fail_cnt;
        o_pending  <= expected_results.size();
        o_taken    <= taken_cnt;
        o_finished <= finished_flag;
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the motion capture recorder: clock, reset, stimulus, register setup, verdict.
module tb_top;
    import mcr_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int         NUM_PHASES = 6;
    localparam int         FILL_PHASE = 2;

    int ph_thr   [NUM_PHASES] = '{819, 0, 65535, 100, 2000, 30000};
    int ph_start [NUM_PHASES] = '{10, 1, 255, 3, 0, 255};
    int ph_stop  [NUM_PHASES] = '{20, 1, 255, 5, 0, 255};
    int ph_items [NUM_PHASES] = '{250, 150, 150, 200, 80, 200};
    int ph_seg   [NUM_PHASES] = '{40, 6, 300, 12, 4, 320};
    int ph_read  [NUM_PHASES] = '{20, 25, 3, 35, 30, 10};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    int          failures;
    int          pending;
    int          taken;
    logic        model_finished;

    int                            burst_left = 0;
    int                            gen_thr    = 819;
    logic signed [SAMPLE_BITS-1:0] last_accel [3] = '{default: '0};
    logic [TIME_W-1:0]             stamp      = '0;
    int                            stall_left = 0;
    int                            stall_mode = 0;
    int                            cyc        = 0;

    motion_capture_recorder_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    mcr_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_taken     (taken),
        .o_finished  (model_finished)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 160);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= cyc[2];
        endcase
    end

    function automatic logic signed [SAMPLE_BITS-1:0] step_axis(
        input logic signed [SAMPLE_BITS-1:0] prior, input bit jump, input int thr);
        int v;
        int d;
        if (jump) begin
            d = thr + 1 + $urandom_range(0, 200);
            v = (prior > 0) ? int'(prior) - d : int'(prior) + d;
        end else begin
            d = $urandom_range(0, (thr < 40) ? thr : 40);
            v = $urandom_range(0, 1) ? int'(prior) + d : int'(prior) - d;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic t_in_item make_sample(input int ax, input int ay, input int az,
                                             input int gx, input int gy, input int gz,
                                             input logic [TIME_W-1:0] t);
        t_in_item req;
        req.opcode  = OP_SAMPLE;
        req.accel_x = 16'(ax);
        req.accel_y = 16'(ay);
        req.accel_z = 16'(az);
        req.gyro_x  = 16'(gx);
        req.gyro_y  = 16'(gy);
        req.gyro_z  = 16'(gz);
        req.time_ms = t;
        return req;
    endfunction

    task automatic push_request(input t_in_item req);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                      : $urandom_range(1, 12);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    task automatic send_random(input logic [1:0] op);
        t_in_item req;
        req = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        req.opcode = op;
        if (op == OP_SAMPLE) begin
            last_accel[0] = req.accel_x;
            last_accel[1] = req.accel_y;
            last_accel[2] = req.accel_z;
        end
        push_request(req);
    endtask

    task automatic send_samples(input bit moving, input int count);
        t_in_item req;
        int       k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(0, 2);
            for (int a = 0; a < 3; a++)
                last_accel[a] = step_axis(last_accel[a], moving && (a == k), gen_thr);
            stamp = stamp + $urandom_range(1, 25);
            req = make_sample(last_accel[0], last_accel[1], last_accel[2],
                              $urandom, $urandom, $urandom, stamp);
            push_request(req);
        end
    endtask

    task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic program_limits(input int thr, input int start, input int stop);
        settle();
        apb_access(1'b1, REG_THRESHOLD, 16'(thr));
        apb_access(1'b1, REG_START_LEN, {8'($urandom), 8'(start)});
        apb_access(1'b1, REG_STOP_LEN, {8'($urandom), 8'(stop)});
        apb_access(1'b1, REG_UNUSED, 16'($urandom));
        apb_access(1'b0, REG_THRESHOLD, '0);
        apb_access(1'b0, REG_START_LEN, '0);
        apb_access(1'b0, REG_STOP_LEN, '0);
        gen_thr = thr;
    endtask

    initial begin
        int target;
        int r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default limits: empty read, idle opcode, extremes, threshold edge, wrap-free drain
        send_random(OP_READ);
        send_random(OP_UNUSED);
        push_request(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 32'hFFFF_FFFF));
        push_request(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'h0));
        push_request(make_sample(-31949, -32768, -32768, 1, -1, 0, 32'h5555_5555));
        push_request(make_sample(-31129, -32768, -32768, 0, 0, 0, 32'hAAAA_AAAA));
        repeat (5) send_random(OP_READ);
        send_random(OP_CLEAR);
        push_request(make_sample(100, 200, 300, 7, 8, 9, 32'd1000));
        send_random(OP_READ);

        // shortest runs: start and finish on single samples, then ignored sample
        program_limits(0, 1, 1);
        push_request(make_sample(100, 200, 300, 1, 2, 3, 32'd1001));
        push_request(make_sample(101, 200, 300, 4, 5, 6, 32'd1002));
        push_request(make_sample(101, 200, 300, 7, 8, 9, 32'd1003));
        push_request(make_sample(5000, -5000, 0, 10, 11, 12, 32'd1004));
        repeat (3) send_random(OP_READ);
        send_random(OP_CLEAR);
        send_random(OP_READ);
        last_accel = '{16'sd101, 16'sd200, 16'sd300};

        for (int p = 0; p < NUM_PHASES; p++) begin
            program_limits(ph_thr[p], ph_start[p], ph_stop[p]);
            if (p == FILL_PHASE) send_samples(1'b0, 530);
            target = taken + ph_items[p];
            while (taken < target) begin
                r = $urandom_range(0, 99);
                if ((model_finished && r < 40) || r < 4) begin
                    send_random(OP_CLEAR);
                end else if (r < 4 + ph_read[p]) begin
                    repeat ($urandom_range(1, 8)) send_random(OP_READ);
                end else if (r < 12 + ph_read[p]) begin
                    repeat ($urandom_range(1, 3)) send_random(2'($urandom_range(0, 3)));
                end else begin
                    send_samples($urandom_range(0, 1), $urandom_range(1, ph_seg[p]));
                end
            end
        end

        settle();
        repeat (5) @(posedge i_clk);
        $display("summary: %0d requests checked over %0d register settings", taken,
                 NUM_PHASES + 2);
        $display("summary: ring overwrite and drain, empty reads, clears, run-length extremes");
        if (failures == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
